// ===== sv/lca_pkg.sv =====
// shared types and constants for the life cellular automaton block
// no dependencies; used by the row chain, rule and top level modules
package lca_pkg;

	localparam int GRID_WIDTH_DEF  = 32;
	localparam int GRID_HEIGHT_DEF = 32;

	localparam int OP_W   = 2;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 5;
	localparam int BITS_W = 32;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_TOGGLE = 2'd0;
	localparam op_t OP_STEP   = 2'd1;
	localparam op_t OP_READ   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

endpackage

// ===== sv/lca_row_chain.sv =====
// chain of row cells holding the grid, one row of cells per stage
// every enabled cycle each stage takes the row of its neighbor; the last stage takes tail_d
// depends on lca_pkg for the default grid size
module lca_row_chain #(
	parameter int GRID_WIDTH  = lca_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lca_pkg::GRID_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic [GRID_WIDTH-1:0] tail_d,
	output logic [GRID_WIDTH-1:0] head0,
	output logic [GRID_WIDTH-1:0] head1
);

	logic [GRID_WIDTH-1:0] rows_q [GRID_HEIGHT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_HEIGHT; i++) begin
				rows_q[i] <= '0;
			end
		end else if (shift_en) begin
			for (int i = 0; i < GRID_HEIGHT - 1; i++) begin
				rows_q[i] <= rows_q[i+1];
			end
			rows_q[GRID_HEIGHT-1] <= tail_d;
		end
	end

	assign head0 = rows_q[0];
	assign head1 = rows_q[1];

endmodule

// ===== sv/lca_rule.sv =====
// b3/s23 rule for one row: next row from the rows above, at and below
// cells beyond the left and right edges count as dead; depends on lca_pkg for the default width
module lca_rule #(
	parameter int GRID_WIDTH = lca_pkg::GRID_WIDTH_DEF
) (
	input  logic [GRID_WIDTH-1:0] above,
	input  logic [GRID_WIDTH-1:0] mid,
	input  logic [GRID_WIDTH-1:0] below,
	output logic [GRID_WIDTH-1:0] next_row
);

	logic [GRID_WIDTH+1:0] a_p, m_p, b_p;

	// dead border column on each side
	assign a_p = {1'b0, above, 1'b0};
	assign m_p = {1'b0, mid, 1'b0};
	assign b_p = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < GRID_WIDTH; c++) begin
			n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
			  + 4'(m_p[c]) + 4'(m_p[c+2])
			  + 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
			next_row[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
		end
	end

endmodule

// ===== sv/life_cellular_automaton_top.sv =====
// top level of the life cellular automaton: control, result capture, output register
// depends on lca_pkg, lca_row_chain and lca_rule
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, operation, row, col  | into block
//  out     | out_valid, out_ready, row_bits, cell_alive | out of block
//
// every transaction rotates the row chain once around
// (accept, one shift per row through the chain, then hand over to the output register)
// a step feeds the rule output into the chain tail; toggle and read feed the head row back
// reset clears the grid to all dead at once; no clearing pass
// in_ready is high only while idle; a full output register holds the finished result back
module life_cellular_automaton_top #(
	parameter int GRID_WIDTH  = lca_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lca_pkg::GRID_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lca_pkg::op_t              operation,
	input  logic [lca_pkg::ROW_W-1:0] row,
	input  logic [lca_pkg::COL_W-1:0] col,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lca_pkg::BITS_W-1:0] row_bits,
	output logic                      cell_alive
);

	import lca_pkg::*;

	localparam int CW  = $clog2(GRID_HEIGHT);
	localparam int PW  = (GRID_WIDTH > BITS_W) ? GRID_WIDTH : BITS_W;
	localparam int PIW = $clog2(PW);

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	op_t                 op_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [GRID_WIDTH-1:0] prev_q;
	logic [BITS_W-1:0]   res_bits_q;
	logic                res_cell_q;
	logic                out_valid_q;
	logic [BITS_W-1:0]   row_bits_q;
	logic                cell_alive_q;

	logic                  accept, running, last, match, col_ok, out_free;
	logic [GRID_WIDTH-1:0] head0, head1, below, next_row, tog_mask, tail_d;
	logic [PW-1:0]         tail_pad;
	logic [PIW-1:0]        col_idx;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign running  = (state_q == ST_RUN);
	assign last     = (cnt_q == CW'(GRID_HEIGHT - 1));
	assign match    = (32'(row_q) == 32'(cnt_q));
	assign col_ok   = (32'(col_q) < 32'(GRID_WIDTH));
	assign out_free = !out_valid_q || out_ready;

	// bottom row sees dead cells below; head1 then already holds a new row
	assign below = last ? '0 : head1;

	lca_rule #(
		.GRID_WIDTH(GRID_WIDTH)
	) u_rule (
		.above   (prev_q),
		.mid     (head0),
		.below   (below),
		.next_row(next_row)
	);

	assign tog_mask = (GRID_WIDTH'(1) << col_q) & {GRID_WIDTH{col_ok}};

	always_comb begin
		if (op_q == OP_STEP) begin
			tail_d = next_row;
		end else if ((op_q == OP_TOGGLE) && match) begin
			tail_d = head0 ^ tog_mask;
		end else begin
			tail_d = head0;
		end
	end

	assign tail_pad = PW'(tail_d);
	assign col_idx  = PIW'(col_q);

	lca_row_chain #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(running),
		.tail_d  (tail_d),
		.head0   (head0),
		.head1   (head1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= operation;
			row_q      <= row;
			col_q      <= col;
			prev_q     <= '0;
			res_bits_q <= '0;
			res_cell_q <= 1'b0;
		end else if (running) begin
			prev_q <= head0;
			// grab the addressed row as it leaves the head, after the operation
			if (match) begin
				res_bits_q <= tail_pad[BITS_W-1:0];
				res_cell_q <= col_ok && tail_pad[col_idx];
			end
		end
		if ((state_q == ST_HOLD) && out_free) begin
			row_bits_q   <= res_bits_q;
			cell_alive_q <= res_cell_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_bits   = row_bits_q;
	assign cell_alive = cell_alive_q;

endmodule

// ===== bench/tb_life_cellular_automaton_top.sv =====
// self-checking testbench for life_cellular_automaton_top: directed table, then random seeding
// and evolution with randomized idle on both channels; depends on lca_pkg and the top level
module tb_life_cellular_automaton_top;
	import lca_pkg::*;

	localparam int  GRID_ROWS      = GRID_HEIGHT_DEF;
	localparam int  GRID_COLS      = GRID_WIDTH_DEF;
	localparam int  RANDOM_ITEMS   = 650;
	localparam int  SETTLE_CYCLES  = GRID_HEIGHT_DEF + 8;
	localparam int  CYCLE_LIMIT    = 400000;
	// unused operation code, the block treats it as a read
	localparam op_t OP_SPARE       = 2'd3;

	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic              alive;
	} life_result_t;

	typedef struct packed {
		op_t               op;
		logic [ROW_W-1:0]  r;
		logic [COL_W-1:0]  c;
		logic              typed;
		logic [BITS_W-1:0] bits;
		logic              alive;
	} probe_row_t;

	localparam int PROBE_COUNT = 26;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	op_t                 operation  = OP_READ;
	logic [ROW_W-1:0]    row        = '0;
	logic [COL_W-1:0]    col        = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [BITS_W-1:0]   row_bits;
	logic                cell_alive;

	logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
	life_result_t         pending_results [$];
	int                   mismatch_count = 0;
	int                   items_sent     = 0;
	bit                   steady_flow    = 1'b0;
	int                   stall_left     = 0;

	probe_row_t probe_table [PROBE_COUNT] = '{
		'{OP_READ,   5'd0,  5'd0,  1'b1, 32'h0000_0000, 1'b0},
		'{OP_READ,   5'd31, 5'd31, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_TOGGLE, 5'd0,  5'd0,  1'b1, 32'h0000_0001, 1'b1},
		'{OP_TOGGLE, 5'd0,  5'd31, 1'b1, 32'h8000_0001, 1'b1},
		'{OP_TOGGLE, 5'd31, 5'd31, 1'b1, 32'h8000_0000, 1'b1},
		'{OP_TOGGLE, 5'd31, 5'd0,  1'b1, 32'h8000_0001, 1'b1},
		'{OP_SPARE,  5'd0,  5'd5,  1'b1, 32'h8000_0001, 1'b0},
		// lone corner cells all die
		'{OP_STEP,   5'd0,  5'd0,  1'b1, 32'h0000_0000, 1'b0},
		'{OP_READ,   5'd31, 5'd31, 1'b1, 32'h0000_0000, 1'b0},
		// 2x2 block in the bottom-left corner, stable across a step
		'{OP_TOGGLE, 5'd31, 5'd0,  1'b1, 32'h0000_0001, 1'b1},
		'{OP_TOGGLE, 5'd31, 5'd1,  1'b1, 32'h0000_0003, 1'b1},
		'{OP_TOGGLE, 5'd30, 5'd0,  1'b1, 32'h0000_0001, 1'b1},
		'{OP_TOGGLE, 5'd30, 5'd1,  1'b1, 32'h0000_0003, 1'b1},
		'{OP_STEP,   5'd31, 5'd1,  1'b1, 32'h0000_0003, 1'b1},
		// blinker in the middle
		'{OP_TOGGLE, 5'd10, 5'd14, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd10, 5'd15, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd10, 5'd16, 1'b0, 32'h0, 1'b0},
		'{OP_STEP,   5'd9,  5'd15, 1'b0, 32'h0, 1'b0},
		'{OP_STEP,   5'd10, 5'd15, 1'b0, 32'h0, 1'b0},
		// glider pressed against the top-right edge
		'{OP_TOGGLE, 5'd0,  5'd30, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd1,  5'd31, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd2,  5'd29, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd2,  5'd30, 1'b0, 32'h0, 1'b0},
		'{OP_TOGGLE, 5'd2,  5'd31, 1'b0, 32'h0, 1'b0},
		'{OP_STEP,   5'd1,  5'd30, 1'b0, 32'h0, 1'b0},
		'{OP_STEP,   5'd0,  5'd31, 1'b0, 32'h0, 1'b0}
	};

	life_cellular_automaton_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.row       (row),
		.col       (col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_bits  (row_bits),
		.cell_alive(cell_alive)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// ---------------- grid model ----------------

	function automatic logic alive_at(input int r, input int c);
		if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
			return 1'b0;
		return life_grid[r][c];
	endfunction

	task automatic evolve_grid();
		logic [GRID_COLS-1:0] next_rows [GRID_ROWS];
		int n;
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							n += alive_at(r + dr, c + dc);
				next_rows[r][c] = (n == 3) || (life_grid[r][c] && n == 2);
			end
		end
		for (int r = 0; r < GRID_ROWS; r++)
			life_grid[r] = next_rows[r];
	endtask

	task automatic predict_item(input op_t op, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, output life_result_t res);
		if (op == OP_TOGGLE) begin
			life_grid[r][c] = ~life_grid[r][c];
		end else if (op == OP_STEP) begin
			evolve_grid();
		end
		res.bits  = life_grid[r][BITS_W-1:0];
		res.alive = life_grid[r][c];
	endtask

	// ---------------- input channel ----------------

	function automatic int idle_length();
		int pick;
		if (steady_flow)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input op_t op, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic typed, input life_result_t typed_res);
		life_result_t res;
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		row       <= r;
		col       <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(op, r, c, res);
		if (typed)
			res = typed_res;
		pending_results.push_back(res);
		items_sent++;
	endtask

	task automatic send_predicted(input op_t op, input int r, input int c);
		send_item(op, r[ROW_W-1:0], c[COL_W-1:0], 1'b0, '0);
	endtask

	// hold the input side until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// seed a 6x6 patch, then let it evolve with reads and noise mixed in
	task automatic seed_and_evolve();
		int base_r, base_c, seeds, gens, extra, pick;
		pick = $urandom_range(0, 5);
		base_r = (pick == 0) ? 0 : (pick == 1) ? GRID_ROWS - 6 : $urandom_range(0, GRID_ROWS - 6);
		pick = $urandom_range(0, 5);
		base_c = (pick == 0) ? 0 : (pick == 1) ? GRID_COLS - 6 : $urandom_range(0, GRID_COLS - 6);
		seeds = $urandom_range(3, 12);
		for (int i = 0; i < seeds; i++)
			send_predicted(OP_TOGGLE, base_r + $urandom_range(0, 5), base_c + $urandom_range(0, 5));
		gens = $urandom_range(1, 6);
		for (int g = 0; g < gens; g++) begin
			send_predicted(OP_STEP, base_r + $urandom_range(0, 5), base_c + $urandom_range(0, 5));
			extra = $urandom_range(0, 2);
			for (int i = 0; i < extra; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					send_predicted(OP_READ, base_r + $urandom_range(0, 5),
						base_c + $urandom_range(0, 5));
				else if (pick < 7)
					send_predicted(OP_SPARE, $urandom_range(0, 31), $urandom_range(0, 31));
				else
					send_predicted(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
						$urandom_range(0, 31));
			end
		end
	endtask

	// ---------------- output channel ----------------

	always @(posedge clk) begin : result_check
		life_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual row_bits %h cell_alive %b",
						$time, row_bits, cell_alive);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (row_bits !== want.bits) begin
						$display("%0t: row_bits mismatch, expected %h, actual %h",
							$time, want.bits, row_bits);
						mismatch_count++;
					end
					if (cell_alive !== want.alive) begin
						$display("%0t: cell_alive mismatch, expected %b, actual %b",
							$time, want.alive, cell_alive);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else begin
				stall_left <= idle_length();
				out_ready  <= 1'b1;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		life_result_t typed_res;
		int episode;
		for (int r = 0; r < GRID_ROWS; r++)
			life_grid[r] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++) begin
			typed_res.bits  = probe_table[i].bits;
			typed_res.alive = probe_table[i].alive;
			send_item(probe_table[i].op, probe_table[i].r, probe_table[i].c,
				probe_table[i].typed, typed_res);
		end
		drain_results();

		episode = 0;
		while (items_sent < PROBE_COUNT + RANDOM_ITEMS) begin
			// every fourth episode runs back to back on both sides
			steady_flow = (episode % 4 == 3);
			if ($urandom_range(0, 4) == 0)
				send_predicted(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
					$urandom_range(0, 31));
			else
				seed_and_evolve();
			if (episode % 10 == 9)
				drain_results();
			episode++;
		end
		steady_flow = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lca_pkg.sv
sv/lca_row_chain.sv
sv/lca_rule.sv
sv/life_cellular_automaton_top.sv
bench/tb_life_cellular_automaton_top.sv
